// ===== rtl/aes_ctr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes_ctr_pkg: shared types, tables and functions
// S-box, round helpers and word structs for the AES-256 CTR keystream unit.
// ----------------------------------------------------------------------------
package aes_ctr_pkg;

  localparam int unsigned NumRounds = 14;
  localparam int unsigned RkWords   = 60;

  localparam logic [2:0] RegKey0     = 3'd0;
  localparam logic [2:0] RegKey1     = 3'd1;
  localparam logic [2:0] RegKey2     = 3'd2;
  localparam logic [2:0] RegKey3     = 3'd3;
  localparam logic [2:0] RegNonceHi  = 3'd4;
  localparam logic [2:0] RegNonceLo  = 3'd5;

  typedef struct packed {
    logic        restart;
    logic [63:0] data_high;
    logic [63:0] data_low;
    logic [4:0]  byte_count;
  } in_word_t;

  typedef struct packed {
    logic [63:0] result_high;
    logic [63:0] result_low;
    logic [4:0]  result_bytes;
  } out_word_t;

  typedef enum logic [1:0] {
    StIdle,
    StKey,
    StRound,
    StOut
  } state_e;

  localparam logic [7:0] Sbox [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    sub_word = {Sbox[w[31:24]], Sbox[w[23:16]], Sbox[w[15:8]], Sbox[w[7:0]]};
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

endpackage

// ===== rtl/aes_ctr_round.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes_ctr_round: one AES encryption round
// SubBytes, ShiftRows, optional MixColumns and AddRoundKey on a 128-bit state.
// ----------------------------------------------------------------------------
module aes_ctr_round (
  input  logic [127:0] state_i,
  input  logic [127:0] rkey_i,
  input  logic         last_i,
  output logic [127:0] state_o
);
  import aes_ctr_pkg::*;

  logic [7:0] s [16];
  logic [7:0] t [16];
  logic [7:0] m [16];

  always_comb begin
    logic [7:0] all;
    for (int i = 0; i < 16; i++) begin
      s[i] = state_i[127 - 8*i -: 8];
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[4*c + r] = Sbox[s[4*((c + r) % 4) + r]];
      end
    end
    for (int c = 0; c < 4; c++) begin
      all = t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
      m[4*c]   = last_i ? t[4*c]   : t[4*c]   ^ all ^ xtime(t[4*c]   ^ t[4*c+1]);
      m[4*c+1] = last_i ? t[4*c+1] : t[4*c+1] ^ all ^ xtime(t[4*c+1] ^ t[4*c+2]);
      m[4*c+2] = last_i ? t[4*c+2] : t[4*c+2] ^ all ^ xtime(t[4*c+2] ^ t[4*c+3]);
      m[4*c+3] = last_i ? t[4*c+3] : t[4*c+3] ^ all ^ xtime(t[4*c+3] ^ t[4*c]);
    end
    for (int i = 0; i < 16; i++) begin
      state_o[127 - 8*i -: 8] = m[i] ^ rkey_i[127 - 8*i -: 8];
    end
  end

endmodule

// ===== rtl/aes256_ctr_keystream_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes256_ctr_keystream_unit: AES-256 counter-mode data path
// Encrypts the running counter with one shared round unit and XORs the
// keystream into each data word.
// ----------------------------------------------------------------------------
//  channel | dir | handshake            | payload
//  in      | in  | in_valid_i/in_ready_o | in_word_t
//  out     | out | out_valid_o/out_ready_i| out_word_t
//  cfg     | in  | cfg_we_i              | cfg_idx_i, cfg_data_i
//
// The initial key add is applied to the counter directly, and the 14 rounds run
// through the single round unit, each firing once its four round-key words are in,
// read one a cycle from a 60-entry memory. A restart word first expands the key
// schedule, one schedule word per cycle. Reset clears control, counter and the
// key and nonce registers, not the round keys or the data registers. A new word
// may be accepted while a result waits; an output stall then holds the last round
// until the output frees.
// ----------------------------------------------------------------------------
module aes256_ctr_keystream_unit (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [2:0]             cfg_idx_i,
  input  logic [63:0]            cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  aes_ctr_pkg::in_word_t  in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output aes_ctr_pkg::out_word_t out_data_o
);
  import aes_ctr_pkg::*;

  logic [63:0] key_q [4];
  logic [63:0] nonce_hi_q, nonce_lo_q;
  logic [63:0] ctr_hi_q, ctr_hi_d, ctr_lo_q, ctr_lo_d;
  state_e      state_q, state_d;
  logic [5:0]  idx_q, idx_d;       // schedule word index / round-key word index
  logic [3:0]  rnd_q, rnd_d;
  in_word_t    item_q;
  logic [127:0] st_q, st_d;
  logic [127:0] rk_buf_q;
  logic [31:0] win_q [8];          // sliding window of the last eight schedule words
  out_word_t   out_q, out_d;
  logic        out_v_q, out_v_d;

  logic [31:0] rk_mem [RkWords];
  logic [31:0] rk_rd_q;
  logic [5:0]  rd_addr;
  logic        rd_en;
  logic [31:0] new_w;
  logic        wr_en;
  logic [127:0] rnd_out;
  logic        fire;
  logic        out_hold;
  logic [127:0] rk_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q[0]   <= '0;
      key_q[1]   <= '0;
      key_q[2]   <= '0;
      key_q[3]   <= '0;
      nonce_hi_q <= '0;
      nonce_lo_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegKey0:    key_q[0]   <= cfg_data_i;
        RegKey1:    key_q[1]   <= cfg_data_i;
        RegKey2:    key_q[2]   <= cfg_data_i;
        RegKey3:    key_q[3]   <= cfg_data_i;
        RegNonceHi: nonce_hi_q <= cfg_data_i;
        RegNonceLo: nonce_lo_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // key schedule step on the window
  always_comb begin
    logic [31:0] t;
    t = win_q[7];
    if (idx_q[2:0] == 3'd0) begin
      t = sub_word({t[23:0], t[31:24]}) ^ {(8'h01 << (idx_q[5:3] - 3'd1)), 24'h0};
    end else if (idx_q[2:0] == 3'd4) begin
      t = sub_word(t);
    end
    new_w = (idx_q < 6'd8) ? key_q[idx_q[2:1]][(idx_q[0] ? 0 : 32) +: 32] : win_q[0] ^ t;
  end

  assign wr_en = (state_q == StKey);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      rk_mem[idx_q] <= new_w;
    end
    if (rd_en) begin
      rk_rd_q <= rk_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      for (int i = 0; i < 7; i++) win_q[i] <= win_q[i+1];
      win_q[7] <= new_w;
    end
  end

  // round keys are fetched one word a cycle; the round fires once four are in
  assign rk_full = {rk_buf_q[95:0], rk_rd_q};

  // last round waits while the previous result still sits in the output register
  assign out_hold = (state_q == StRound) && (rnd_q == 4'(NumRounds)) &&
                    (idx_q[1:0] == 2'd0) && out_v_q && !out_ready_i;

  aes_ctr_round u_round (
    .state_i (st_q),
    .rkey_i  (rk_full),
    .last_i  (rnd_q == 4'(NumRounds)),
    .state_o (rnd_out)
  );

  always_comb begin
    logic [4:0] cnt;
    logic [63:0] kh, kl;
    state_d = state_q;
    idx_d   = idx_q;
    rnd_d   = rnd_q;
    st_d    = st_q;
    ctr_hi_d = ctr_hi_q;
    ctr_lo_d = ctr_lo_q;
    out_d   = out_q;
    out_v_d = out_v_q;
    rd_en   = 1'b0;
    rd_addr = idx_q;
    fire    = 1'b0;
    cnt     = (item_q.byte_count > 5'd16) ? 5'd16 : item_q.byte_count;
    kh = '0; kl = '0;
    if (out_v_q && out_ready_i) out_v_d = 1'b0;
    case (state_q)
      StIdle: begin
        if (in_valid_i && in_ready_o) begin
          idx_d = '0;
          if (in_data_i.restart) begin
            ctr_hi_d = nonce_hi_q;
            ctr_lo_d = nonce_lo_q;
            state_d  = StKey;
          end else begin
            state_d = StRound;
            rd_en = 1'b1;
            rd_addr = '0;
            idx_d = 6'd1;
          end
          rnd_d = '0;
        end
      end
      StKey: begin
        idx_d = idx_q + 6'd1;
        if (idx_q == 6'(RkWords - 1)) begin
          state_d = StRound;
          idx_d = 6'd1;
          rd_en = 1'b1;
          rd_addr = '0;
        end
      end
      StRound: begin
        if (rnd_q == '0 && idx_q == 6'd1) st_d = {ctr_hi_q, ctr_lo_q};
        if (idx_q[1:0] == 2'd0 && !out_hold) begin
          fire = 1'b1;
          st_d = (rnd_q == '0) ? ({ctr_hi_q, ctr_lo_q} ^ rk_full) : rnd_out;
        end
        if (fire && rnd_q == 4'(NumRounds)) begin
          for (int i = 0; i < 8; i++) begin
            kh[63 - 8*i -: 8] = (5'(i) < cnt) ?
              (item_q.data_high[63 - 8*i -: 8] ^ rnd_out[127 - 8*i -: 8]) : 8'h00;
            kl[63 - 8*i -: 8] = (5'(i + 8) < cnt) ?
              (item_q.data_low[63 - 8*i -: 8] ^ rnd_out[63 - 8*i -: 8]) : 8'h00;
          end
          out_d = '{result_high: kh, result_low: kl, result_bytes: item_q.byte_count};
          out_v_d = 1'b1;
          ctr_lo_d = ctr_lo_q + 64'd1;
          state_d = StOut;
        end else begin
          if (fire) rnd_d = rnd_q + 4'd1;
          if (idx_q != 6'(RkWords)) begin
            rd_en = 1'b1;
            rd_addr = idx_q;
            idx_d = idx_q + 6'd1;
          end
        end
      end
      StOut: begin
        // low half wrapped to zero: carry into the high half
        if (ctr_lo_q == '0) ctr_hi_d = ctr_hi_q + 64'd1;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  // round-key word buffer: fire uses the four words, so it collects throughout the rounds unless the last round is held
  always_ff @(posedge clk_i) begin
    if (state_q == StRound && !out_hold) rk_buf_q <= rk_full;
  end

  assign in_ready_o = (state_q == StIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      out_v_q  <= 1'b0;
      ctr_hi_q <= '0;
      ctr_lo_q <= '0;
      idx_q    <= '0;
      rnd_q    <= '0;
    end else begin
      state_q  <= state_d;
      out_v_q  <= out_v_d;
      ctr_hi_q <= ctr_hi_d;
      ctr_lo_q <= ctr_lo_d;
      idx_q    <= idx_d;
      rnd_q    <= rnd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    st_q  <= st_d;
    out_q <= out_d;
    if (in_valid_i && in_ready_o) item_q <= in_data_i;
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

endmodule
